// File: design/sorted_name_table_defines.svh
// ---------------------------------------------------------------------------
// sorted_name_table_defines: assertion macros for the sorted name table
// ---------------------------------------------------------------------------
`ifndef SORTED_NAME_TABLE_DEFINES_SVH
`define SORTED_NAME_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// when a holds, b holds in the same cycle
`define SNT_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sorted_name_table: check failed");

// when a holds, b holds in the next cycle
`define SNT_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sorted_name_table: check failed");

`else

`define SNT_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define SNT_ASSERT_NEXT(lbl, clk, rst_n, a, b)

`endif

`endif

// File: design/sntab_pkg.sv
// ---------------------------------------------------------------------------
// sntab_pkg
// Types and constants shared by the sorted name table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package sntab_pkg;

    localparam int ENTRIES_DEFAULT     = 128;
    localparam int NAME_BYTES_DEFAULT  = 128;
    localparam int MIN_LENGTH_DEFAULT  = 4;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // command codes on tuser
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_BSEARCH = 2'd1;
    localparam logic [1:0] CMD_LSEARCH = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    typedef enum logic [2:0] {
        OP_BYTE    = 3'd0,
        OP_INSERT  = 3'd1,
        OP_BSEARCH = 3'd2,
        OP_LSEARCH = 3'd3,
        OP_DROP    = 3'd4
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } item_t;

endpackage

`default_nettype wire

// File: design/sntab_front.sv
// ---------------------------------------------------------------------------
// sntab_front
// Input register stage: accepts byte transactions and tags each with its op.
// ---------------------------------------------------------------------------
`default_nettype none

module sntab_front
    import sntab_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] in_cmd,
    input  wire logic [7:0] in_ch,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output item_t           out_item
);

    logic  valid_reg, valid_next;
    item_t item_reg;
    op_t   op_class;

    always_comb
    begin
        if (!in_last)
        begin
            op_class = OP_BYTE;
        end
        else
        begin
            unique case (in_cmd)
                CMD_INSERT:  op_class = OP_INSERT;
                CMD_BSEARCH: op_class = OP_BSEARCH;
                CMD_LSEARCH: op_class = OP_LSEARCH;
                default:     op_class = OP_DROP;
            endcase
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.op <= op_class;
            item_reg.ch <= in_ch;
        end
    end

endmodule

`default_nettype wire

// File: design/sntab_queue.sv
// ---------------------------------------------------------------------------
// sntab_queue
// Short FIFO of tagged items between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module sntab_queue
    import sntab_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          slots [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic           push, pop;

    assign in_ready  = fill_reg != CW'(DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_item  = slots[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: design/sntab_back.sv
// ---------------------------------------------------------------------------
// sntab_back
// Execution engine: buffers the name, searches, inserts, emits results.
// ---------------------------------------------------------------------------
`default_nettype none

module sntab_back
    import sntab_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEFAULT,
    parameter int NAME_BYTES = NAME_BYTES_DEFAULT,
    parameter int MIN_LENGTH = MIN_LENGTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire item_t      in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      out_status,
    output logic [6:0]      out_index,
    output logic [7:0]      out_total
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = $clog2(ENTRIES);
    localparam int QW = $clog2(NAME_BYTES);
    localparam int JW = $clog2(NAME_BYTES + 1);
    localparam int AW = $clog2(ENTRIES * NAME_BYTES);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PROBE = 10'b0000000010,
        S_PTR   = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_EVAL  = 10'b0000010000,
        S_STEP  = 10'b0000100000,
        S_SHIFT = 10'b0001000000,
        S_SHWR  = 10'b0010000000,
        S_PAD   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    // memories: name rows, query bytes, sorted order of rows
    logic [7:0]    name_mem [ENTRIES * NAME_BYTES];
    logic [7:0]    qbuf_mem [NAME_BYTES];
    logic [RW-1:0] ptr_mem  [ENTRIES];

    state_t        state_reg, state_next;
    logic [QW-1:0] qlen_reg, qlen_next;
    logic          over_reg, over_next;
    logic [CW-1:0] count_reg, count_next;
    logic [JW-1:0] len_reg, len_next;
    op_t           mode_reg, mode_next;
    logic [CW-1:0] lo_reg, lo_next, hn_reg, hn_next;
    logic [RW-1:0] mid_reg, mid_next;
    logic [JW-1:0] j_reg, j_next;
    logic          lt_reg, lt_next, eq_reg, eq_next;
    logic [CW-1:0] pos_reg, pos_next, k_reg, k_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic [CW-1:0] res_index_reg, res_index_next;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_status_reg;
    logic [6:0]    out_index_reg;
    logic [7:0]    out_total_reg;

    logic          name_we;
    logic [AW-1:0] name_waddr, name_raddr;
    logic [7:0]    name_wdata, name_q;
    logic          qbuf_we;
    logic [7:0]    qbuf_q;
    logic          ptr_we, ptr_re;
    logic [RW-1:0] ptr_waddr, ptr_raddr, ptr_wdata, ptr_q;

    logic          take, fits, room;
    logic [JW-1:0] len_new;
    logic [CW:0]   span;
    logic [7:0]    q_byte;
    logic          load_out;
    logic [31:0]   idx_wide, total_wide;

    assign take    = in_valid && (state_reg == S_IDLE);
    assign fits    = qlen_reg != QW'(NAME_BYTES - 1);
    assign room    = count_reg != CW'(ENTRIES);
    assign len_new = JW'(qlen_reg) + JW'(fits);
    assign span    = (CW+1)'(lo_reg) + (CW+1)'(hn_reg);
    assign q_byte  = (j_reg < len_reg) ? qbuf_q : 8'd0;

    assign in_ready = state_reg == S_IDLE;
    assign qbuf_we  = take && fits;

    always_comb
    begin
        state_next      = state_reg;
        qlen_next       = qlen_reg;
        over_next       = over_reg;
        count_next      = count_reg;
        len_next        = len_reg;
        mode_next       = mode_reg;
        lo_next         = lo_reg;
        hn_next         = hn_reg;
        mid_next        = mid_reg;
        j_next          = j_reg;
        lt_next         = lt_reg;
        eq_next         = eq_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        load_out        = 1'b0;
        name_we         = 1'b0;
        name_waddr      = AW'(count_reg[RW-1:0]) * AW'(NAME_BYTES) + AW'(qlen_reg);
        name_wdata      = in_item.ch;
        name_raddr      = AW'(ptr_q) * AW'(NAME_BYTES) + AW'(j_reg);
        ptr_we          = 1'b0;
        ptr_re          = 1'b0;
        ptr_waddr       = k_reg[RW-1:0];
        ptr_wdata       = ptr_q;
        ptr_raddr       = mid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    // the name's row is filled as bytes arrive, at the next free row
                    name_we   = fits && room;
                    qlen_next = fits ? qlen_reg + 1'b1 : qlen_reg;
                    over_next = over_reg || !fits;
                    if (in_item.op != OP_BYTE)
                    begin
                        qlen_next       = '0;
                        over_next       = 1'b0;
                        len_next        = len_new;
                        mode_next       = in_item.op;
                        lo_next         = '0;
                        hn_next         = count_reg;
                        res_index_next  = '0;
                        res_status_next = ST_NOT_FOUND;
                        if (in_item.op == OP_DROP)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (over_reg || !fits)
                        begin
                            res_status_next = ST_TOO_LONG;
                            state_next      = S_OUT;
                        end
                        else if (len_new < JW'(MIN_LENGTH))
                        begin
                            res_status_next = ST_TOO_SHORT;
                            state_next      = S_OUT;
                        end
                        else if (in_item.op == OP_INSERT && !room)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            state_next = S_PROBE;
                        end
                    end
                end
            end

            S_PROBE:
            begin
                if (lo_reg < hn_reg)
                begin
                    priority case (mode_reg)
                        OP_BSEARCH: mid_next = RW'((span - 1'b1) >> 1);
                        OP_INSERT:  mid_next = RW'(span >> 1);
                        default:    mid_next = lo_reg[RW-1:0];
                    endcase
                    ptr_re     = 1'b1;
                    ptr_raddr  = mid_next;
                    state_next = S_PTR;
                end
                else if (mode_reg == OP_INSERT)
                begin
                    pos_next   = lo_reg;
                    k_next     = count_reg;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_PTR:
            begin
                j_next     = '0;
                state_next = S_RD;
            end

            S_RD:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (name_q != q_byte)
                begin
                    lt_next    = name_q < q_byte;
                    eq_next    = 1'b0;
                    state_next = S_STEP;
                end
                else if (j_reg == JW'(NAME_BYTES - 1))
                begin
                    lt_next    = 1'b0;
                    eq_next    = 1'b1;
                    state_next = S_STEP;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RD;
                end
            end

            S_STEP:
            begin
                state_next = S_PROBE;
                priority case (mode_reg)
                    OP_INSERT:
                    begin
                        if (lt_reg || eq_reg)
                            lo_next = CW'(mid_reg) + 1'b1;
                        else
                            hn_next = CW'(mid_reg);
                    end
                    OP_BSEARCH:
                    begin
                        if (eq_reg)
                        begin
                            res_status_next = ST_FOUND;
                            res_index_next  = CW'(mid_reg);
                            state_next      = S_OUT;
                        end
                        else if (lt_reg)
                            lo_next = CW'(mid_reg) + 1'b1;
                        else
                            hn_next = CW'(mid_reg);
                    end
                    default:
                    begin
                        if (eq_reg)
                        begin
                            res_status_next = ST_FOUND;
                            res_index_next  = CW'(mid_reg);
                            state_next      = S_OUT;
                        end
                        else
                            lo_next = lo_reg + 1'b1;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // open a gap in the sorted order, top entry first
                if (k_reg > pos_reg)
                begin
                    ptr_re     = 1'b1;
                    ptr_raddr  = RW'(k_reg - 1'b1);
                    state_next = S_SHWR;
                end
                else
                begin
                    ptr_we     = 1'b1;
                    ptr_waddr  = pos_reg[RW-1:0];
                    ptr_wdata  = count_reg[RW-1:0];
                    j_next     = len_reg;
                    state_next = S_PAD;
                end
            end

            S_SHWR:
            begin
                ptr_we     = 1'b1;
                k_next     = k_reg - 1'b1;
                state_next = S_SHIFT;
            end

            S_PAD:
            begin
                // zero the row past the name's end
                if (j_reg < JW'(NAME_BYTES))
                begin
                    name_we    = 1'b1;
                    name_waddr = AW'(count_reg[RW-1:0]) * AW'(NAME_BYTES) + AW'(j_reg);
                    name_wdata = 8'd0;
                    j_next     = j_reg + 1'b1;
                end
                else
                begin
                    count_next      = count_reg + 1'b1;
                    res_status_next = ST_INSERTED;
                    res_index_next  = pos_reg;
                    state_next      = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign idx_wide   = 32'(res_index_reg);
    assign total_wide = 32'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            qlen_reg      <= '0;
            over_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            qlen_reg      <= qlen_next;
            over_reg      <= over_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        mode_reg       <= mode_next;
        lo_reg         <= lo_next;
        hn_reg         <= hn_next;
        mid_reg        <= mid_next;
        j_reg          <= j_next;
        lt_reg         <= lt_next;
        eq_reg         <= eq_next;
        pos_reg        <= pos_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= idx_wide[6:0];
            out_total_reg  <= total_wide[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[name_waddr] <= name_wdata;
        end
        name_q <= name_mem[name_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (qbuf_we)
        begin
            qbuf_mem[qlen_reg] <= in_item.ch;
        end
        qbuf_q <= qbuf_mem[j_reg[QW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[ptr_waddr] <= ptr_wdata;
        end
        if (ptr_re)
        begin
            ptr_q <= ptr_mem[ptr_raddr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_total  = out_total_reg;

endmodule

`default_nettype wire

// File: design/sorted_name_table.sv
// Sorted name table: one byte per transaction, buffered in the engine as it arrives.
// Each probe reads the row pointer, then the name compare goes byte by byte, up to NAME_BYTES bytes.
// Binary search and insert probe about log2(entries) rows; linear search up to all rows.
// Insert also moves each row above the insert point up in the order table and zero-pads the new row up to NAME_BYTES.
// Reset (rst_n, async, active low) empties the table at once; no clearing pass.
// ---------------------------------------------------------------------------
// sorted_name_table
// Top level: front stage, item queue and execution engine.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_name_table_defines.svh"

module sorted_name_table
    import sntab_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEFAULT,
    parameter int NAME_BYTES = NAME_BYTES_DEFAULT,
    parameter int MIN_LENGTH = MIN_LENGTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [2:0] status, [9:3] index, [17:10] entry_total
);

    logic       f_valid, f_ready, q_valid, q_ready;
    item_t      f_item, q_item;
    logic [2:0] status;
    logic [6:0] index;
    logic [7:0] entry_total;

    sntab_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .in_ch     (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    sntab_queue #(
        .DEPTH (QUEUE_DEPTH_DEFAULT)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    sntab_back #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES),
        .MIN_LENGTH (MIN_LENGTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_index  (index),
        .out_total  (entry_total)
    );

    assign m_axis_tdata = {6'd0, entry_total, index, status};

    `SNT_ASSERT_IMPLY(a_status_code, clk, rst_n, m_axis_tvalid, status <= ST_TOO_LONG)
    `SNT_ASSERT_IMPLY(a_index_zero, clk, rst_n, m_axis_tvalid && status > ST_FOUND, index == 7'd0)
    `SNT_ASSERT_IMPLY(a_total_bound, clk, rst_n, m_axis_tvalid && ENTRIES < 256, 32'(entry_total) <= ENTRIES)
    `SNT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Streams names into the sorted name table a byte per transaction, predicts
// each insert and search result in a local copy of the table, and compares
// every result transaction field by field, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb_top;
    import sntab_pkg::*;

    localparam int         TABLE_ROWS = 128;
    localparam int         ROW_BYTES  = 128;
    localparam int         SHORTEST   = 4;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         TAIL_WAIT  = 40000;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] index;
        logic [7:0] total;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    // local copy of the table
    bit [7:0] rows [TABLE_ROWS][ROW_BYTES];
    int       row_count;
    bit [7:0] qbuf [ROW_BYTES];
    int       qlen;
    bit       qover;

    // names already inserted, reused as search keys
    bit [7:0] known_nm [256][ROW_BYTES];
    int       known_len [256];
    int       known_count;

    bit [7:0] nm [140];
    int       nm_len;

    result_t  pending_results [$];
    int       errors;
    bit       quiet;

    sorted_name_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #1000ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int row_vs_query(int r);
        bit [7:0] q;
        for (int i = 0; i < ROW_BYTES; i++)
        begin
            q = (i < qlen) ? qbuf[i] : 8'h00;
            if (rows[r][i] != q)
                return (rows[r][i] < q) ? -1 : 1;
        end
        return 0;
    endfunction

    // advance the local table by one accepted byte
    task automatic predict_byte(logic [1:0] cmd, logic [7:0] ch, logic last);
        result_t r;
        int      pos;
        int      lo;
        int      hi;
        int      mid;
        int      c;
        if (qlen < ROW_BYTES - 1)
        begin
            qbuf[qlen] = ch;
            qlen++;
        end
        else
            qover = 1'b1;
        if (!last)
            return;
        if (cmd == CMD_UNUSED)
        begin
            qlen  = 0;
            qover = 1'b0;
            return;
        end
        r.status = ST_NOT_FOUND;
        r.index  = '0;
        if (qover)
            r.status = ST_TOO_LONG;
        else if (qlen < SHORTEST)
            r.status = ST_TOO_SHORT;
        else if (cmd == CMD_INSERT)
        begin
            if (row_count >= TABLE_ROWS)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < row_count && row_vs_query(pos) <= 0)
                    pos++;
                for (int k = row_count; k > pos; k--)
                    rows[k] = rows[k - 1];
                for (int i = 0; i < ROW_BYTES; i++)
                    rows[pos][i] = (i < qlen) ? qbuf[i] : 8'h00;
                row_count++;
                r.status = ST_INSERTED;
                r.index  = pos[6:0];
                for (int i = 0; i < qlen; i++)
                    known_nm[known_count % 256][i] = qbuf[i];
                known_len[known_count % 256] = qlen;
                known_count++;
            end
        end
        else if (cmd == CMD_BSEARCH)
        begin
            lo = 0;
            hi = row_count - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                c   = row_vs_query(mid);
                if (c == 0)
                begin
                    r.status = ST_FOUND;
                    r.index  = mid[6:0];
                    break;
                end
                else if (c > 0)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        else
        begin
            for (int i = 0; i < row_count; i++)
            begin
                if (row_vs_query(i) == 0)
                begin
                    r.status = ST_FOUND;
                    r.index  = i[6:0];
                    break;
                end
            end
        end
        qlen    = 0;
        qover   = 1'b0;
        r.total = row_count[7:0];
        pending_results.push_back(r);
    endtask

    task automatic send_byte(logic [1:0] cmd, logic [7:0] ch, logic last);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < 35)
                gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_byte(cmd, ch, last);
    endtask

    task automatic send_name(logic [1:0] cmd);
        for (int i = 0; i < nm_len; i++)
            send_byte(cmd, nm[i], i == nm_len - 1);
    endtask

    task automatic make_name(int len, bit wide);
        nm_len = len;
        for (int i = 0; i < len; i++)
            nm[i] = wide ? 8'($urandom_range(255)) : 8'($urandom_range(8'h44, 8'h41));
    endtask

    task automatic pick_known();
        int k;
        k = $urandom_range((known_count > 256 ? 256 : known_count) - 1);
        nm_len = known_len[k];
        for (int i = 0; i < nm_len; i++)
            nm[i] = known_nm[k][i];
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", int'(m_axis_tdata), 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[2:0] != want.status)
                    report_mismatch("status", int'(m_axis_tdata[2:0]), int'(want.status));
                if (m_axis_tdata[9:3] != want.index)
                    report_mismatch("index", int'(m_axis_tdata[9:3]), int'(want.index));
                if (m_axis_tdata[17:10] != want.total)
                    report_mismatch("entry_total", int'(m_axis_tdata[17:10]),
                                    int'(want.total));
            end
        end
    end

    // short names, byte extremes, zero byte, the unused command
    task automatic test_edges();
        for (int l = 1; l <= 3; l++)
        begin
            make_name(l, 1'b0);
            send_name(CMD_INSERT);
            send_name(CMD_BSEARCH);
            send_name(CMD_LSEARCH);
        end
        make_name(4, 1'b0);
        send_name(CMD_BSEARCH);
        send_name(CMD_LSEARCH);
        nm_len = 4;
        nm = '{default: 8'hFF};
        send_name(CMD_INSERT);
        nm = '{default: 8'h01};
        send_name(CMD_INSERT);
        nm[2] = 8'h00;
        send_name(CMD_INSERT);
        send_name(CMD_BSEARCH);
        nm[3] = 8'h00;
        send_name(CMD_LSEARCH);
        make_name(5, 1'b1);
        send_name(CMD_UNUSED);
        send_name(CMD_INSERT);
        send_name(CMD_INSERT);
        send_name(CMD_INSERT);
        send_name(CMD_BSEARCH);
        send_name(CMD_LSEARCH);
    endtask

    // longest name that fits, and a name one byte too long
    task automatic test_long_names();
        make_name(ROW_BYTES - 1, 1'b1);
        send_name(CMD_INSERT);
        make_name(ROW_BYTES, 1'b0);
        send_name(CMD_BSEARCH);
    endtask

    task automatic test_random(int byte_budget);
        int  sent;
        int  pick;
        logic [1:0] cmd;
        sent = 0;
        while (sent < byte_budget)
        begin
            quiet = (sent > byte_budget / 2 && sent < byte_budget / 2 + 80);
            pick  = $urandom_range(99);
            cmd   = pick < 45 ? CMD_INSERT : pick < 80 ? CMD_BSEARCH :
                    pick < 96 ? CMD_LSEARCH : CMD_UNUSED;
            if (row_count >= 40 && cmd == CMD_INSERT)
                cmd = CMD_BSEARCH;
            if (cmd != CMD_INSERT && known_count > 0 && $urandom_range(99) < 60)
                pick_known();
            else
                make_name($urandom_range(99) < 10 ? $urandom_range(3, 1)
                                                   : $urandom_range(8, 4),
                          $urandom_range(99) < 25);
            send_name(cmd);
            sent += nm_len;
        end
        quiet = 1'b0;
    endtask

    // fill the table, then one insert too many and a search of each kind
    task automatic test_full_table();
        while (row_count < TABLE_ROWS)
        begin
            make_name(4, 1'b1);
            send_name(CMD_INSERT);
        end
        make_name(4, 1'b0);
        send_name(CMD_INSERT);
        pick_known();
        send_name(CMD_BSEARCH);
        send_name(CMD_LSEARCH);
    endtask

    initial
    begin
        errors        = 0;
        quiet         = 1'b0;
        row_count     = 0;
        qlen          = 0;
        qover         = 1'b0;
        known_count   = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_INSERT;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edges();
        test_long_names();
        test_random(150);
        test_full_table();

        drain();
        repeat (TAIL_WAIT) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
